[src/bdls_pkg.sv]
// ----------------------------------------------------------------------------
// Battery display level smoother: shared definitions
// Field widths, charger and mode codes, and the reset value of the ramp
// length register.
// ----------------------------------------------------------------------------
package bdls_pkg;

    // Field widths
    localparam int unsigned CS_W    = 2;
    localparam int unsigned LEVEL_W = 7;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned TRANS_W = 16;

    // Full charge in percent
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 7'd100;

    // Ramp length after reset, in seconds
    localparam logic [TRANS_W-1:0] TRANSITION_RESET = 16'd900;

    // Charger status codes; anything else means no usable power source
    localparam logic [CS_W-1:0] CS_FULL     = 2'd0;
    localparam logic [CS_W-1:0] CS_CHARGING = 2'd1;

    // Display modes, as reported on the output
    localparam logic [MODE_W-1:0] MODE_INACTIVE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WAIT_EOC = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RECHARGE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OVERLOAD = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NO_POWER = 3'd4;

    // Ramp arithmetic: numerator 201*T - 2*(100-level)*elapsed fits in 25 bits
    localparam int unsigned ACC_W  = 25;
    // Multiplier digits: the constant 201 and twice the level deficit
    localparam int unsigned MULD_W = 8;
    localparam logic [MULD_W-1:0] RAMP_TOP_FACTOR = 8'd201;

endpackage

[src/battery_display_level_smoother.sv]
// ----------------------------------------------------------------------------
// Battery display level smoother
// Turns charger status, gauge level and a seconds timestamp into the level to
// display, holding 100 through the recharge cycle and ramping down linearly
// to the true level when power is lost or the battery is overloaded.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  ------------------------------
//  in        input      i_in_valid / o_in_stall    charger_state, gauge_level,
//                                                  now_seconds
//  out       output     o_out_valid / i_out_stall  shown_level, mode_now
//  cfg       input      i_cfg_wr_en                transition_seconds
//
//  Outside a ramp an update goes from the input registers through S_EVAL into
//  the result register and, in S_OUT, into the output register. During a ramp
//  the ramp numerator is built in S_MUL one multiplier bit per cycle and then
//  divided by twice the ramp length in S_DIV one quotient bit per cycle, before
//  S_FIN sets the result and S_OUT moves it out.
//  One update is in work at a time; the next is taken once the current result
//  has moved into the output register, which holds it while i_out_stall is
//  high. Reset is synchronous and active low and restores the inactive mode.
//
module battery_display_level_smoother (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write
    input  logic                            i_cfg_wr_en,
    input  logic [bdls_pkg::TRANS_W-1:0]    i_cfg_wr_data,
    // Input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bdls_pkg::CS_W-1:0]       i_charger_state,
    input  logic [bdls_pkg::LEVEL_W-1:0]    i_gauge_level,
    input  logic [bdls_pkg::TIME_W-1:0]     i_now_seconds,
    // Output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bdls_pkg::LEVEL_W-1:0]    o_shown_level,
    output logic [bdls_pkg::MODE_W-1:0]     o_mode_now
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    // Registers
    t_state                           r_state, n_state;
    logic [bdls_pkg::TRANS_W-1:0]     r_trans, n_trans;
    logic [bdls_pkg::MODE_W-1:0]      r_mode, n_mode;
    logic [bdls_pkg::LEVEL_W-1:0]     r_mark, n_mark;
    logic [bdls_pkg::TIME_W-1:0]      r_ramp_start, n_ramp_start;
    logic [bdls_pkg::CS_W-1:0]        r_cs, n_cs;
    logic [bdls_pkg::LEVEL_W-1:0]     r_lvl, n_lvl;
    logic [bdls_pkg::TIME_W-1:0]      r_now, n_now;
    logic [bdls_pkg::ACC_W-1:0]       r_acc, n_acc;
    logic [bdls_pkg::ACC_W-1:0]       r_ta, n_ta;
    logic [bdls_pkg::ACC_W-1:0]       r_ea, n_ea;
    logic [bdls_pkg::MULD_W-1:0]      r_mt, n_mt;
    logic [bdls_pkg::MULD_W-1:0]      r_md, n_md;
    logic [bdls_pkg::ACC_W-1:0]       r_div, n_div;
    logic [bdls_pkg::LEVEL_W-1:0]     r_q, n_q;
    logic [2:0]                       r_cnt, n_cnt;
    logic [bdls_pkg::LEVEL_W-1:0]     r_res_level, n_res_level;
    logic [bdls_pkg::MODE_W-1:0]      r_res_mode, n_res_mode;
    logic                             r_out_valid, n_out_valid;
    logic [bdls_pkg::LEVEL_W-1:0]     r_out_level, n_out_level;
    logic [bdls_pkg::MODE_W-1:0]      r_out_mode, n_out_mode;

    // Helper signals
    logic                             in_xfer;
    logic                             out_xfer;
    logic [bdls_pkg::LEVEL_W-1:0]     lvl_clamped;
    logic [bdls_pkg::TRANS_W-1:0]     eff_trans;
    logic [bdls_pkg::TIME_W-1:0]      elapsed;
    logic                             ramp_over;
    logic [bdls_pkg::LEVEL_W-1:0]     deficit;
    logic [bdls_pkg::ACC_W-1:0]       acc_step;
    logic                             div_fits;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_xfer = r_out_valid && !i_out_stall;

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_shown_level = r_out_level;
    assign o_mode_now    = r_out_mode;

    // Levels above full count as full
    assign lvl_clamped = (i_gauge_level > bdls_pkg::FULL_LEVEL) ? bdls_pkg::FULL_LEVEL
                                                                  : i_gauge_level;

    // A ramp length of zero behaves as one second
    assign eff_trans = (r_trans == '0) ? {{(bdls_pkg::TRANS_W-1){1'b0}}, 1'b1} : r_trans;

    // Time since the ramp began, modulo 2^32
    assign elapsed   = r_now - r_ramp_start;
    assign ramp_over = elapsed > {{(bdls_pkg::TIME_W-bdls_pkg::TRANS_W){1'b0}}, eff_trans};
    assign deficit   = bdls_pkg::FULL_LEVEL - r_lvl;

    // One multiplier bit: add T<<k for the constant, subtract elapsed<<k for 2*deficit
    assign acc_step = r_acc + (r_mt[0] ? r_ta : '0) - (r_md[0] ? r_ea : '0);

    // One restoring division bit
    assign div_fits = (r_acc >= r_div);

    // Next-state logic
    always_comb begin
        n_state      = r_state;
        n_trans      = r_trans;
        n_mode       = r_mode;
        n_mark       = r_mark;
        n_ramp_start = r_ramp_start;
        n_cs         = r_cs;
        n_lvl        = r_lvl;
        n_now        = r_now;
        n_acc        = r_acc;
        n_ta         = r_ta;
        n_ea         = r_ea;
        n_mt         = r_mt;
        n_md         = r_md;
        n_div        = r_div;
        n_q          = r_q;
        n_cnt        = r_cnt;
        n_res_level  = r_res_level;
        n_res_mode   = r_res_mode;
        n_out_valid  = r_out_valid;
        n_out_level  = r_out_level;
        n_out_mode   = r_out_mode;

        // Configuration write
        if (i_cfg_wr_en) begin
            n_trans = i_cfg_wr_data;
        end

        // The output register empties on a transfer
        if (out_xfer) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cs    = i_charger_state;
                    n_lvl   = lvl_clamped;
                    n_now   = i_now_seconds;
                    n_state = S_EVAL;
                end
            end

            S_EVAL: begin
                // By default the true level is shown and the mode stays
                n_res_level = r_lvl;
                n_res_mode  = r_mode;
                n_state     = S_OUT;
                case (r_mode)
                    bdls_pkg::MODE_INACTIVE, bdls_pkg::MODE_WAIT_EOC: begin
                        if ((r_mode == bdls_pkg::MODE_WAIT_EOC) ||
                            (r_lvl >= bdls_pkg::FULL_LEVEL)) begin
                            if (r_mode == bdls_pkg::MODE_INACTIVE) begin
                                n_mark = '0;
                            end
                            if (r_cs == bdls_pkg::CS_FULL) begin
                                n_res_mode  = bdls_pkg::MODE_RECHARGE;
                                n_res_level = bdls_pkg::FULL_LEVEL;
                            end else if (r_cs != bdls_pkg::CS_CHARGING) begin
                                n_ramp_start = r_now;
                                n_res_mode   = bdls_pkg::MODE_NO_POWER;
                                n_res_level  = bdls_pkg::FULL_LEVEL;
                            end else begin
                                n_res_mode = bdls_pkg::MODE_WAIT_EOC;
                            end
                        end
                    end

                    bdls_pkg::MODE_RECHARGE: begin
                        n_res_level = bdls_pkg::FULL_LEVEL;
                        if (r_cs == bdls_pkg::CS_FULL) begin
                            n_mark = '0;
                        end else if (r_cs == bdls_pkg::CS_CHARGING) begin
                            if (r_mark == '0) begin
                                n_mark = r_lvl;
                            end else if (r_lvl < r_mark) begin
                                // Draining while on the charger: overloaded
                                n_ramp_start = r_now;
                                n_res_mode   = bdls_pkg::MODE_OVERLOAD;
                            end
                        end else begin
                            n_ramp_start = r_now;
                            n_res_mode   = bdls_pkg::MODE_NO_POWER;
                        end
                    end

                    bdls_pkg::MODE_OVERLOAD, bdls_pkg::MODE_NO_POWER: begin
                        if (ramp_over) begin
                            n_res_mode = bdls_pkg::MODE_INACTIVE;
                        end else begin
                            // Start the serial product for the ramp numerator
                            n_acc   = '0;
                            n_ta    = {{(bdls_pkg::ACC_W-bdls_pkg::TRANS_W){1'b0}}, eff_trans};
                            n_ea    = {{(bdls_pkg::ACC_W-bdls_pkg::TRANS_W){1'b0}},
                                       elapsed[bdls_pkg::TRANS_W-1:0]};
                            n_mt    = bdls_pkg::RAMP_TOP_FACTOR;
                            n_md    = {deficit, 1'b0};
                            n_cnt   = '0;
                            n_state = S_MUL;
                        end
                    end

                    default: begin
                        n_res_mode = bdls_pkg::MODE_WAIT_EOC;
                    end
                endcase
            end

            S_MUL: begin
                n_acc = acc_step;
                n_ta  = {r_ta[bdls_pkg::ACC_W-2:0], 1'b0};
                n_ea  = {r_ea[bdls_pkg::ACC_W-2:0], 1'b0};
                n_mt  = {1'b0, r_mt[bdls_pkg::MULD_W-1:1]};
                n_md  = {1'b0, r_md[bdls_pkg::MULD_W-1:1]};
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    // Divisor 2*T aligned to the top quotient bit
                    n_div   = {2'b00, eff_trans, {(bdls_pkg::LEVEL_W){1'b0}}};
                    n_q     = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end

            S_DIV: begin
                if (div_fits) begin
                    n_acc = r_acc - r_div;
                end
                n_q   = {r_q[bdls_pkg::LEVEL_W-2:0], div_fits};
                n_div = {1'b0, r_div[bdls_pkg::ACC_W-1:1]};
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd6) begin
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                n_state = S_OUT;
                if ((r_q == r_lvl) && (r_q != bdls_pkg::FULL_LEVEL)) begin
                    // Ramp has met the true level: ramp finished
                    n_res_level = r_lvl;
                    n_res_mode  = bdls_pkg::MODE_INACTIVE;
                end else begin
                    n_res_level = r_q;
                    n_res_mode  = r_mode;
                    if ((r_cs == bdls_pkg::CS_CHARGING) && (r_q == bdls_pkg::FULL_LEVEL) &&
                        (r_lvl >= r_mark)) begin
                        n_res_mode = bdls_pkg::MODE_RECHARGE;
                        n_mark     = r_q;
                    end
                end
            end

            S_OUT: begin
                // Move the result out once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_level = r_res_level;
                    n_out_mode  = r_res_mode;
                    n_mode      = r_res_mode;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_trans      <= bdls_pkg::TRANSITION_RESET;
            r_mode       <= bdls_pkg::MODE_INACTIVE;
            r_mark       <= '0;
            r_ramp_start <= '0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_trans      <= n_trans;
            r_mode       <= n_mode;
            r_mark       <= n_mark;
            r_ramp_start <= n_ramp_start;
            r_out_valid  <= n_out_valid;
            r_cnt        <= n_cnt;
        end
        r_cs        <= n_cs;
        r_lvl       <= n_lvl;
        r_now       <= n_now;
        r_acc       <= n_acc;
        r_ta        <= n_ta;
        r_ea        <= n_ea;
        r_mt        <= n_mt;
        r_md        <= n_md;
        r_div       <= n_div;
        r_q         <= n_q;
        r_res_level <= n_res_level;
        r_res_mode  <= n_res_mode;
        r_out_level <= n_out_level;
        r_out_mode  <= n_out_mode;
    end

endmodule
